[hw/rtl/md5_pkg.sv]
package md5_pkg;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } md5_in_t;

    typedef struct packed {
        logic [63:0] digest_high;
        logic [63:0] digest_low;
    } md5_out_t;

    localparam logic CMD_ABSORB = 1'b0;
    localparam logic CMD_FINISH = 1'b1;

    localparam logic [31:0] IV_A = 32'h67452301;
    localparam logic [31:0] IV_B = 32'hefcdab89;
    localparam logic [31:0] IV_C = 32'h98badcfe;
    localparam logic [31:0] IV_D = 32'h10325476;
    localparam logic [7:0]  PAD_BYTE = 8'h80;

    function automatic logic [31:0] md5_k(input logic [5:0] i);
        logic [31:0] k;
        case (i)
            6'd0: k = 32'hd76aa478; 6'd1: k = 32'he8c7b756;
            6'd2: k = 32'h242070db; 6'd3: k = 32'hc1bdceee;
            6'd4: k = 32'hf57c0faf; 6'd5: k = 32'h4787c62a;
            6'd6: k = 32'ha8304613; 6'd7: k = 32'hfd469501;
            6'd8: k = 32'h698098d8; 6'd9: k = 32'h8b44f7af;
            6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
            6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193;
            6'd14: k = 32'ha679438e; 6'd15: k = 32'h49b40821;
            6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
            6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa;
            6'd20: k = 32'hd62f105d; 6'd21: k = 32'h02441453;
            6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
            6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6;
            6'd26: k = 32'hf4d50d87; 6'd27: k = 32'h455a14ed;
            6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
            6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a;
            6'd32: k = 32'hfffa3942; 6'd33: k = 32'h8771f681;
            6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
            6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9;
            6'd38: k = 32'hf6bb4b60; 6'd39: k = 32'hbebfbc70;
            6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
            6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05;
            6'd44: k = 32'hd9d4d039; 6'd45: k = 32'he6db99e5;
            6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
            6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97;
            6'd50: k = 32'hab9423a7; 6'd51: k = 32'hfc93a039;
            6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
            6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1;
            6'd56: k = 32'h6fa87e4f; 6'd57: k = 32'hfe2ce6e0;
            6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
            6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235;
            6'd62: k = 32'h2ad7d2bb; 6'd63: k = 32'heb86d391;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [4:0] md5_s(input logic [5:0] i);
        logic [4:0] s;
        case ({i[5:4], i[1:0]})
            4'd0: s = 5'd7;  4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
            4'd4: s = 5'd5;  4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
            4'd8: s = 5'd4;  4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
            4'd12: s = 5'd6; 4'd13: s = 5'd10; 4'd14: s = 5'd15; 4'd15: s = 5'd21;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

endpackage

[hw/rtl/md5_queue.sv]
module md5_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  md5_pkg::md5_in_t wr_data,
    input  logic            wr_en,
    output logic            full,
    output md5_pkg::md5_in_t rd_data,
    output logic            rd_valid,
    input  logic            rd_en
);
    import md5_pkg::*;

    md5_in_t    mem_reg [4];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] cnt_reg;

    assign full     = (cnt_reg == 3'd4);
    assign rd_valid = (cnt_reg != 3'd0);
    assign rd_data  = mem_reg[rp_reg];

    always_ff @(posedge clk) begin
        if (wr_en && !full) begin
            mem_reg[wp_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else begin
            if (wr_en && !full) begin
                wp_reg <= wp_reg + 2'd1;
            end
            if (rd_en && rd_valid) begin
                rp_reg <= rp_reg + 2'd1;
            end
            cnt_reg <= cnt_reg + {2'd0, wr_en && !full} - {2'd0, rd_en && rd_valid};
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= 3'd4)
        else $error("Queue count exceeds its depth.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (wr_en && !full && !(rd_en && rd_valid)) |=> cnt_reg == $past(cnt_reg) + 3'd1)
        else $error("Queue count failed to rise on a write.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_valid == 1'b0) |-> (wp_reg == rp_reg))
        else $error("Empty queue has unequal pointers.");
endmodule

[hw/rtl/md5_core.sv]
module md5_core (
    input  logic             clk,
    input  logic             rst_n,
    input  md5_pkg::md5_in_t item,
    input  logic             item_valid,
    output logic             item_take,
    output md5_pkg::md5_out_t result,
    output logic             empty,
    input  logic             pop
);
    import md5_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_LOAD, S_ROUND, S_ADD, S_PAD, S_EMIT
    } state_t;

    state_t      state_reg;
    logic [31:0] buf_reg [16];
    logic [5:0]  fill_reg;
    logic [63:0] len_reg;
    logic [63:0] flen_reg;
    logic [31:0] h_reg [4];
    logic [31:0] a_reg, b_reg, c_reg, d_reg;
    logic [31:0] w_reg;
    logic [5:0]  rnd_reg;
    logic        fin_reg;
    logic        out_valid_reg;
    logic        len_block_reg;
    md5_out_t    out_reg;

    logic [31:0] f_val, t_val, rot_val;
    logic [3:0]  g_idx, g_next;
    logic [5:0]  rnd_inc;
    logic [7:0]  pad_byte;
    logic [4:0]  sh;

    function automatic logic [3:0] g_of(input logic [5:0] i);
        logic [3:0] g;
        case (i[5:4])
            2'd0: g = i[3:0];
            2'd1: g = 4'(i[3:0] * 4'd5 + 4'd1);
            2'd2: g = 4'(i[3:0] * 4'd3 + 4'd5);
            default: g = 4'(i[3:0] * 4'd7);
        endcase
        return g;
    endfunction

    function automatic logic [63:0] pack(input logic [31:0] x, input logic [31:0] y);
        return {x[7:0], x[15:8], x[23:16], x[31:24], y[7:0], y[15:8], y[23:16], y[31:24]};
    endfunction

    assign rnd_inc = rnd_reg + 6'd1;
    assign g_idx   = g_of(rnd_reg);
    assign g_next  = g_of(rnd_inc);
    assign sh      = md5_s(rnd_reg);

    always_comb begin
        case (rnd_reg[5:4])
            2'd0:    f_val = (b_reg & c_reg) | (~b_reg & d_reg);
            2'd1:    f_val = (b_reg & d_reg) | (c_reg & ~d_reg);
            2'd2:    f_val = b_reg ^ c_reg ^ d_reg;
            default: f_val = c_reg ^ (b_reg | ~d_reg);
        endcase
        t_val   = a_reg + f_val + w_reg + md5_k(rnd_reg);
        rot_val = (t_val << sh) | (t_val >> (6'd32 - {1'b0, sh}));
    end

    always_comb begin
        if (len_block_reg && fill_reg >= 6'd56) begin
            pad_byte = flen_reg[{fill_reg[2:0], 3'b000} +: 8];
        end
        else begin
            pad_byte = 8'h00;
        end
    end

    assign item_take = (state_reg == S_IDLE) && item_valid;
    assign empty     = !out_valid_reg;
    assign result    = out_reg;

    always_ff @(posedge clk) begin
        if (item_take && item.command == CMD_ABSORB) begin
            buf_reg[fill_reg[5:2]][{fill_reg[1:0], 3'b000} +: 8] <= item.data_byte;
        end
        else if (item_take) begin
            buf_reg[fill_reg[5:2]][{fill_reg[1:0], 3'b000} +: 8] <= PAD_BYTE;
        end
        else if (state_reg == S_PAD) begin
            buf_reg[fill_reg[5:2]][{fill_reg[1:0], 3'b000} +: 8] <= pad_byte;
        end
        if (state_reg == S_LOAD) begin
            w_reg <= buf_reg[g_idx];
        end
        else if (state_reg == S_ROUND) begin
            w_reg <= buf_reg[g_next];
        end
        if (item_take && item.command == CMD_FINISH) begin
            flen_reg <= len_reg;
        end
        if (state_reg == S_EMIT && !out_valid_reg) begin
            out_reg.digest_high <= pack(h_reg[0], h_reg[1]);
            out_reg.digest_low  <= pack(h_reg[2], h_reg[3]);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            len_reg       <= '0;
            h_reg[0]      <= IV_A;
            h_reg[1]      <= IV_B;
            h_reg[2]      <= IV_C;
            h_reg[3]      <= IV_D;
            a_reg         <= '0;
            b_reg         <= '0;
            c_reg         <= '0;
            d_reg         <= '0;
            rnd_reg       <= '0;
            fin_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (pop && out_valid_reg) begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (item_take) begin
                        fin_reg  <= item.command;
                        fill_reg <= fill_reg + 6'd1;
                        if (item.command == CMD_ABSORB) begin
                            len_reg <= len_reg + 64'd8;
                        end
                        if (fill_reg == 6'd63) begin
                            state_reg <= S_LOAD;
                        end
                        else if (item.command == CMD_FINISH) begin
                            state_reg <= S_PAD;
                        end
                    end
                end
                S_PAD: begin
                    fill_reg <= fill_reg + 6'd1;
                    if (fill_reg == 6'd63) begin
                        state_reg <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    a_reg     <= h_reg[0];
                    b_reg     <= h_reg[1];
                    c_reg     <= h_reg[2];
                    d_reg     <= h_reg[3];
                    rnd_reg   <= '0;
                    state_reg <= S_ROUND;
                end
                S_ROUND: begin
                    a_reg   <= d_reg;
                    d_reg   <= c_reg;
                    c_reg   <= b_reg;
                    b_reg   <= b_reg + rot_val;
                    rnd_reg <= rnd_inc;
                    if (rnd_reg == 6'd63) begin
                        state_reg <= S_ADD;
                    end
                end
                S_ADD: begin
                    h_reg[0] <= h_reg[0] + a_reg;
                    h_reg[1] <= h_reg[1] + b_reg;
                    h_reg[2] <= h_reg[2] + c_reg;
                    h_reg[3] <= h_reg[3] + d_reg;
                    if (!fin_reg) begin
                        state_reg <= S_IDLE;
                    end
                    else if (len_block_reg) begin
                        state_reg <= S_EMIT;
                    end
                    else begin
                        state_reg <= S_PAD;
                    end
                end
                S_EMIT: begin
                    if (!out_valid_reg) begin
                        out_valid_reg <= 1'b1;
                        h_reg[0]  <= IV_A;
                        h_reg[1]  <= IV_B;
                        h_reg[2]  <= IV_C;
                        h_reg[3]  <= IV_D;
                        len_reg   <= '0;
                        fin_reg   <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            len_block_reg <= 1'b0;
        end
        else if (state_reg == S_IDLE && item_take) begin
            len_block_reg <= (item.command == CMD_FINISH) && (fill_reg < 6'd56);
        end
        else if (state_reg == S_ADD && fin_reg) begin
            len_block_reg <= 1'b1;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && rnd_reg == 6'd63) |=> state_reg == S_ADD)
        else $error("Compression did not end after the last round.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT && !out_valid_reg) |=> (out_valid_reg && h_reg[0] == IV_A))
        else $error("Digest transfer did not restore the initial chaining words.");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> fill_reg == 6'd0)
        else $error("Compression started on a partial block.");
endmodule

[hw/rtl/md5_message_digest_unit.sv]
// MD5 digest engine taking one message byte per transfer and giving one 128-bit
// digest per finish command. The front queue holds four items; the back end
// absorbs one byte at a time and runs a compression (a load step, one step per
// round and an add step) on every full block, taking no new byte while it
// compresses. A finish writes the padding bytes one at a time and runs one or
// two compressions; the digest waits in an output register until it is popped.
module md5_message_digest_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  md5_pkg::md5_in_t  in_data,
    input  logic              push,
    output logic              full,
    output md5_pkg::md5_out_t out_data,
    output logic              empty,
    input  logic              pop
);
    import md5_pkg::*;

    md5_in_t q_data;
    logic    q_valid, q_take;

    md5_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (in_data),
        .wr_en    (push),
        .full     (full),
        .rd_data  (q_data),
        .rd_valid (q_valid),
        .rd_en    (q_take)
    );

    md5_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (q_data),
        .item_valid (q_valid),
        .item_take  (q_take),
        .result     (out_data),
        .empty      (empty),
        .pop        (pop)
    );
endmodule

[tb/md5_digest_checker.sv]
module md5_digest_checker (
    input  logic              clk,
    input  logic              rst_n,
    input  md5_pkg::md5_in_t  in_data,
    input  logic              push,
    input  logic              full,
    input  md5_pkg::md5_out_t out_data,
    input  logic              empty,
    input  logic              pop,
    output int                fail_count,
    output int                pending_digests
);
    import md5_pkg::*;

    localparam logic [31:0] ROUND_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };
    localparam int ROT [4][4] = '{'{7, 12, 17, 22}, '{5, 9, 14, 20},
                                  '{4, 11, 16, 23}, '{6, 10, 15, 21}};

    logic [31:0] chain [4];
    logic [7:0]  buffer [64];
    int          fill;
    logic [63:0] msg_bits;
    md5_out_t    digest_queue [$];

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        return (v << s) | (v >> (32 - s));
    endfunction

    function automatic logic [63:0] byte_swap_pair(input logic [31:0] w0,
                                                   input logic [31:0] w1);
        return {w0[7:0], w0[15:8], w0[23:16], w0[31:24],
                w1[7:0], w1[15:8], w1[23:16], w1[31:24]};
    endfunction

    task automatic restart_message();
        chain[0] = IV_A;
        chain[1] = IV_B;
        chain[2] = IV_C;
        chain[3] = IV_D;
        fill = 0;
        msg_bits = '0;
    endtask

    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, f, t;
        int g, ph;
        for (int i = 0; i < 16; i++)
            w[i] = {buffer[4*i+3], buffer[4*i+2], buffer[4*i+1], buffer[4*i]};
        a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
        for (int i = 0; i < 64; i++)
        begin
            ph = i / 16;
            case (ph)
                0: begin f = (b & c) | (~b & d); g = i; end
                1: begin f = (b & d) | (c & ~d); g = (5 * i + 1) % 16; end
                2: begin f = b ^ c ^ d; g = (3 * i + 5) % 16; end
                default: begin f = c ^ (b | ~d); g = (7 * i) % 16; end
            endcase
            t = a + f + w[g] + ROUND_K[i];
            a = d; d = c; c = b;
            b = b + rotl(t, ROT[ph][i % 4]);
        end
        chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    endtask

    task automatic append_byte(input logic [7:0] v);
        buffer[fill] = v;
        fill++;
        if (fill == 64)
        begin
            compress_block();
            fill = 0;
        end
    endtask

    task automatic absorb_or_finish(input md5_in_t item);
        logic [63:0] len;
        if (item.command == CMD_ABSORB)
        begin
            msg_bits += 64'd8;
            append_byte(item.data_byte);
        end
        else
        begin
            len = msg_bits;
            append_byte(PAD_BYTE);
            while (fill != 56)
                append_byte(8'h00);
            for (int i = 0; i < 8; i++)
                append_byte(len[8*i +: 8]);
            digest_queue.push_back({byte_swap_pair(chain[0], chain[1]),
                                    byte_swap_pair(chain[2], chain[3])});
            restart_message();
        end
    endtask

    initial
    begin
        fail_count = 0;
        pending_digests = 0;
        restart_message();
    end

    always @(posedge clk)
    begin
        md5_out_t exp_d;
        if (rst_n)
        begin
            if (push && !full)
                absorb_or_finish(in_data);
            if (pop && !empty)
            begin
                if (digest_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected digest transfer: %h %h",
                                 out_data.digest_high, out_data.digest_low);
                end
                else
                begin
                    exp_d = digest_queue.pop_front();
                    if (out_data.digest_high !== exp_d.digest_high
                        || out_data.digest_low !== exp_d.digest_low)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Digest mismatch: expected %h %h, got %h %h",
                                     exp_d.digest_high, exp_d.digest_low,
                                     out_data.digest_high, out_data.digest_low);
                    end
                end
            end
            pending_digests = digest_queue.size();
        end
    end
endmodule

[tb/md5_message_digest_unit_tb.sv]
module md5_message_digest_unit_tb;
    import md5_pkg::*;

    logic     clk;
    logic     rst_n;
    md5_in_t  in_data;
    logic     push;
    logic     full;
    md5_out_t out_data;
    logic     empty;
    logic     pop;
    int       fail_count;
    int       pending_digests;
    int       cycle_count;
    bit       calm_phase;

    md5_message_digest_unit u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_data  (in_data),
        .push     (push),
        .full     (full),
        .out_data (out_data),
        .empty    (empty),
        .pop      (pop)
    );

    md5_digest_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_data         (in_data),
        .push            (push),
        .full            (full),
        .out_data        (out_data),
        .empty           (empty),
        .pop             (pop),
        .fail_count      (fail_count),
        .pending_digests (pending_digests)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    task automatic send_item(input logic cmd, input logic [7:0] value);
        int gap;
        if (!calm_phase && $urandom_range(0, 5) == 0)
        begin
            gap = $urandom_range(1, 13);
            push <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        push <= 1'b1;
        in_data <= '{command: cmd, data_byte: value};
        @(posedge clk);
        while (full)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic send_message(input int length);
        for (int i = 0; i < length; i++)
            send_item(CMD_ABSORB, 8'($urandom));
        send_item(CMD_FINISH, 8'($urandom));
    endtask

    always @(negedge clk)
    begin
        int stall;
        if (!rst_n)
            pop <= 1'b0;
        else if (!calm_phase && $urandom_range(0, 7) == 0)
        begin
            stall = $urandom_range(1, 13);
            pop <= 1'b0;
            repeat (stall - 1) @(negedge clk);
        end
        else
            pop <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > 2000000)
        begin
            $display("md5_message_digest_unit_tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        int items;
        int len;
        cycle_count = 0;
        calm_phase = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        in_data = '0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty message, finish with a nonzero data byte, single-byte extremes.
        send_item(CMD_FINISH, 8'hff);
        send_item(CMD_ABSORB, 8'h00);
        send_item(CMD_FINISH, 8'h00);
        send_item(CMD_ABSORB, 8'hff);
        send_item(CMD_FINISH, 8'hff);
        send_item(CMD_ABSORB, 8'haa);
        send_item(CMD_ABSORB, 8'h55);
        send_item(CMD_FINISH, 8'h5a);

        // Padding overflow around 55, 56 and 63 bytes, and a full block.
        send_message(55);
        send_message(56);
        send_message(63);
        send_message(64);

        items = 250;
        while (items < 1250)
        begin
            if (items > 1000)
                calm_phase = 1'b1;
            case ($urandom_range(0, 3))
                0: len = $urandom_range(0, 8);
                1: len = $urandom_range(52, 68);
                default: len = $urandom_range(0, 130);
            endcase
            send_message(len);
            items += len + 1;
        end
        push <= 1'b0;

        while (pending_digests != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (fail_count == 0)
            $display("md5_message_digest_unit_tb: done, clean");
        else
            $display("md5_message_digest_unit_tb: done, errors");
        $finish;
    end
endmodule
